@@ rtl/cnm_pkg.sv @@
package cnm_pkg;

  localparam int MAX_NODES   = 1024;
  localparam int ADDR_W      = $clog2(MAX_NODES);
  localparam int CNT_W       = $clog2(MAX_NODES + 1);
  localparam int ID_W        = 24;
  localparam int COORD_W     = 32;
  localparam int TOL_W       = 31;
  localparam int CMP_W       = COORD_W + 2;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1);

  typedef struct packed {
    logic                      first_of_set;
    logic [ID_W-1:0]           node_id;
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;
    logic                      excluded;
  } in_t;

  typedef struct packed {
    logic [ID_W-1:0] merge_to_id;
    logic            store_full;
  } out_t;

  typedef struct packed {
    logic                      clear;
    logic                      eligible;
    logic [ID_W-1:0]           node_id;
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;
  } cmd_t;

  typedef struct packed {
    logic [ID_W-1:0]           node_id;
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;
  } node_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

endpackage

@@ rtl/cnm_front.sv @@
module cnm_front import cnm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic q_valid,
  output cmd_t q_cmd,
  input  logic q_pop
);

  cmd_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   fill_r, fill_nxt;
  logic              push;
  cmd_t              cmd_in;

  // classify
  always_comb begin
    cmd_in.clear    = in_data.first_of_set;
    cmd_in.eligible = !in_data.excluded && (in_data.node_id != '0);
    cmd_in.node_id  = in_data.node_id;
    cmd_in.x_coord  = in_data.x_coord;
    cmd_in.y_coord  = in_data.y_coord;
  end

  assign in_stall = (fill_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (fill_r != '0);
  assign q_cmd    = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    fill_nxt   = fill_r;
    if (push && !q_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (!push && q_pop) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

@@ rtl/cnm_back.sv @@
module cnm_back import cnm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [TOL_W-1:0] tolerance,
  input  logic             q_valid,
  input  cmd_t             q_cmd,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output out_t             out_data
);

  node_t mem [MAX_NODES];
  node_t rd_data_r;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             rd_pend_r, rd_pend_nxt;
  logic             found_r, found_nxt;
  logic             out_valid_r, out_valid_nxt;

  cmd_t              cmd_r, cmd_nxt;
  logic [ID_W-1:0]   target_r, target_nxt;
  out_t              out_data_r, out_data_nxt;
  logic signed [CMP_W-1:0] lo_x_r, lo_x_nxt, hi_x_r, hi_x_nxt;
  logic signed [CMP_W-1:0] lo_y_r, lo_y_nxt, hi_y_r, hi_y_nxt;

  logic signed [CMP_W-1:0] tol_ext, qx_ext, qy_ext, sx_ext, sy_ext;
  logic mem_we, rd_en, match, out_free, full;

  assign tol_ext  = $signed({(CMP_W-TOL_W)'(0), tolerance});
  assign qx_ext   = CMP_W'(q_cmd.x_coord);
  assign qy_ext   = CMP_W'(q_cmd.y_coord);
  assign sx_ext   = CMP_W'(rd_data_r.x_coord);
  assign sy_ext   = CMP_W'(rd_data_r.y_coord);
  assign match    = (sx_ext > lo_x_r) && (sx_ext < hi_x_r) &&
                    (sy_ext > lo_y_r) && (sy_ext < hi_y_r);
  assign out_free = !out_valid_r || !out_stall;
  assign full     = (count_r == CNT_W'(MAX_NODES));

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    rd_pend_nxt   = rd_pend_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd_nxt       = cmd_r;
    target_nxt    = target_r;
    out_data_nxt  = out_data_r;
    lo_x_nxt      = lo_x_r;
    hi_x_nxt      = hi_x_r;
    lo_y_nxt      = lo_y_r;
    hi_y_nxt      = hi_y_r;
    q_pop         = 1'b0;
    mem_we        = 1'b0;
    rd_en         = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop       = 1'b1;
          cmd_nxt     = q_cmd;
          idx_nxt     = '0;
          rd_pend_nxt = 1'b0;
          found_nxt   = 1'b0;
          target_nxt  = '0;
          lo_x_nxt    = qx_ext - tol_ext;
          hi_x_nxt    = qx_ext + tol_ext;
          lo_y_nxt    = qy_ext - tol_ext;
          hi_y_nxt    = qy_ext + tol_ext;
          if (q_cmd.clear) begin
            count_nxt = '0;
          end
          state_nxt = q_cmd.eligible ? ST_SCAN : ST_FINISH;
        end
      end
      ST_SCAN: begin
        rd_pend_nxt = 1'b0;
        if (rd_pend_r && !found_r && match) begin
          found_nxt  = 1'b1;
          target_nxt = rd_data_r.node_id;
        end
        if (found_r || (idx_r == count_r && !rd_pend_r)) begin
          state_nxt = ST_FINISH;
        end else if (idx_r != count_r) begin
          rd_en       = 1'b1;
          idx_nxt     = idx_r + 1'b1;
          rd_pend_nxt = 1'b1;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.merge_to_id = target_r;
          out_data_nxt.store_full  = cmd_r.eligible && full;
          if (cmd_r.eligible && !full) begin
            mem_we    = 1'b1;
            count_nxt = count_r + 1'b1;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      rd_pend_r   <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      rd_pend_r   <= rd_pend_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    target_r   <= target_nxt;
    out_data_r <= out_data_nxt;
    lo_x_r     <= lo_x_nxt;
    hi_x_r     <= hi_x_nxt;
    lo_y_r     <= lo_y_nxt;
    hi_y_r     <= hi_y_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count_r[ADDR_W-1:0]] <= '{node_id: cmd_r.node_id,
                                    x_coord: cmd_r.x_coord,
                                    y_coord: cmd_r.y_coord};
    end
    if (rd_en) begin
      rd_data_r <= mem[idx_r[ADDR_W-1:0]];
    end
  end

endmodule

@@ rtl/coincident_node_merger.sv @@
// Coincident node merger. Each request carries one node; every request
// returns one result with the id of the first earlier stored node lying
// within the tolerance on both axes (0 if none), and store_full when an
// eligible node found the 1024-entry store already full. The time of an
// eligible node is set by the single read port of the node store, which is
// scanned one entry per cycle in arrival order and stops at the first match;
// excluded or id-zero nodes are not scanned.
// A two-entry request queue lets the input side keep accepting while a
// scan runs, and a result register holds a finished result while the
// output side stalls. Write cfg_wr_data only while the block is idle.
module coincident_node_merger import cnm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_t              in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_t             out_data,
  input  logic             cfg_wr_en,
  input  logic [TOL_W-1:0] cfg_wr_data
);

  logic [TOL_W-1:0] tol_r;
  logic             q_valid;
  logic             q_pop;
  cmd_t             q_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_wr_en) begin
      tol_r <= cfg_wr_data;
    end
  end

  cnm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop)
  );

  cnm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tolerance (tol_r),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ dv/tb_coincident_node_merger.sv @@
module tb_coincident_node_merger;
  import cnm_pkg::*;

  localparam int QUIET_LIMIT = 20000;
  localparam int HOLD_CYCLES = 300;
  localparam int FILL_NODES  = 48;

  class node_merge_tracker;
    logic [TOL_W-1:0]          tol;
    logic [ID_W-1:0]           node_ids [MAX_NODES];
    logic signed [COORD_W-1:0] node_xs [MAX_NODES];
    logic signed [COORD_W-1:0] node_ys [MAX_NODES];
    int unsigned               node_count;
    out_t                      pending_merges [$];
    int unsigned               errors;

    function new();
      tol        = TOL_RESET;
      node_count = 0;
      errors     = 0;
    endfunction

    function void set_tolerance(logic [TOL_W-1:0] value);
      tol = value;
    endfunction

    function int unsigned pending();
      return pending_merges.size();
    endfunction

    function bit within_tol(logic signed [COORD_W-1:0] a, logic signed [COORD_W-1:0] b);
      longint d;
      d = longint'(a) - longint'(b);
      if (d < 0) d = -d;
      return d < longint'({1'b0, tol});
    endfunction

    function void note_request(in_t req);
      out_t res;
      int unsigned k;
      res = '0;
      if (req.first_of_set) node_count = 0;
      if (!req.excluded && req.node_id != '0) begin
        for (k = 0; k < node_count; k++) begin
          if (within_tol(node_xs[k], req.x_coord) && within_tol(node_ys[k], req.y_coord)) begin
            res.merge_to_id = node_ids[k];
            break;
          end
        end
        if (node_count < MAX_NODES) begin
          node_ids[node_count] = req.node_id;
          node_xs[node_count]  = req.x_coord;
          node_ys[node_count]  = req.y_coord;
          node_count++;
        end else begin
          res.store_full = 1'b1;
        end
      end
      pending_merges.push_back(res);
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (pending_merges.size() == 0) begin
        errors++;
        $display("%0t: unexpected result merge_to_id=%h store_full=%b", $time,
                 got.merge_to_id, got.store_full);
        return;
      end
      want = pending_merges.pop_front();
      if (got.merge_to_id !== want.merge_to_id) begin
        errors++;
        $display("%0t: merge_to_id expected %h actual %h", $time,
                 want.merge_to_id, got.merge_to_id);
      end
      if (got.store_full !== want.store_full) begin
        errors++;
        $display("%0t: store_full expected %b actual %b", $time,
                 want.store_full, got.store_full);
      end
    endfunction
  endclass

  logic             clk         = 1'b0;
  logic             rst_n       = 1'b0;
  logic             in_valid    = 1'b0;
  logic             in_stall;
  in_t              in_data     = '0;
  logic             out_valid;
  logic             out_stall   = 1'b0;
  out_t             out_data;
  logic             cfg_wr_en   = 1'b0;
  logic [TOL_W-1:0] cfg_wr_data = '0;

  node_merge_tracker merges;
  int unsigned       send_idle_pct = 26;
  int unsigned       recv_idle_pct = 67;
  logic              start_hold    = 1'b0;
  int unsigned       hold_left     = 0;
  int unsigned       quiet_cycles  = 0;

  coincident_node_merger i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // hold off the result side on request, otherwise stall at random
  always @(posedge clk) begin
    if (start_hold) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
    out_stall <= start_hold || hold_left > 1 || ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) merges.check_result(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("%0t: no request or result moved for %0d cycles", $time, QUIET_LIMIT);
          $display("[coincident_node_merger] ERROR");
          $finish;
        end
      end
    end
  end

  function automatic in_t node_req(bit first, logic [ID_W-1:0] id,
                                   logic signed [COORD_W-1:0] x,
                                   logic signed [COORD_W-1:0] y, bit excl);
    in_t req;
    req.first_of_set = first;
    req.node_id      = id;
    req.x_coord      = x;
    req.y_coord      = y;
    req.excluded     = excl;
    return req;
  endfunction

  task automatic send_node(input in_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    merges.note_request(req);
  endtask

  // drain, then write while the block is idle
  task automatic write_tolerance(input logic [TOL_W-1:0] value);
    in_valid <= 1'b0;
    while (merges.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    merges.set_tolerance(value);
  endtask

  // clustered node sets with random content, plus noise
  task automatic run_sets(input int unsigned n_eligible);
    int unsigned               done_cnt;
    int unsigned               set_len;
    int unsigned               n_centers;
    int unsigned               pick;
    int unsigned               k;
    int unsigned               c;
    logic signed [COORD_W-1:0] cx [4];
    logic signed [COORD_W-1:0] cy [4];
    longint                    span;
    longint                    tol_l;
    in_t                       req;
    done_cnt = 0;
    tol_l    = longint'({1'b0, merges.tol});
    span     = 2 * tol_l + 1;
    if (span > 64'sh0000_0000_FFFF_FFFF) span = 64'sh0000_0000_FFFF_FFFF;
    while (done_cnt < n_eligible) begin
      set_len   = ($urandom_range(9) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 10);
      n_centers = $urandom_range(1, 4);
      for (c = 0; c < 4; c++) begin
        cx[c] = $urandom();
        cy[c] = $urandom();
      end
      for (k = 0; k < set_len; k++) begin
        pick             = $urandom_range(n_centers - 1);
        req.first_of_set = (k == 0) ? ($urandom_range(9) != 0) : ($urandom_range(49) == 0);
        req.node_id      = ($urandom_range(19) == 0) ? '0 : ID_W'($urandom());
        req.excluded     = ($urandom_range(11) == 0);
        if ($urandom_range(15) == 0) begin
          req.x_coord = $urandom();
          req.y_coord = $urandom();
        end else begin
          req.x_coord = 32'(longint'(cx[pick]) + longint'({32'b0, $urandom()}) % span - tol_l);
          req.y_coord = 32'(longint'(cy[pick]) + longint'({32'b0, $urandom()}) % span - tol_l);
        end
        send_node(req);
        if (!req.excluded && req.node_id != '0) done_cnt++;
      end
    end
  endtask

  initial begin
    logic signed [COORD_W-1:0] base;
    int unsigned               k;
    merges = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    send_node(node_req(1'b1, 24'd1, 32'sd0, 32'sd0, 1'b0));
    send_node(node_req(1'b0, 24'd2, 32'sd0, 32'sd0, 1'b0));
    send_node(node_req(1'b0, 24'd3, 32'sd1, 32'sd0, 1'b0));
    send_node(node_req(1'b0, 24'd4, 32'sd0, 32'sd0, 1'b1));
    send_node(node_req(1'b0, 24'd0, 32'sd0, 32'sd0, 1'b0));
    send_node(node_req(1'b0, 24'hFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0));
    send_node(node_req(1'b0, 24'd5, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0));
    send_node(node_req(1'b0, 24'd6, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0));
    send_node(node_req(1'b0, 24'd7, 32'sd0, 32'sd0, 1'b0));
    write_tolerance('0);
    send_node(node_req(1'b0, 24'd8, 32'sd0, 32'sd0, 1'b0));
    send_node(node_req(1'b0, 24'd9, 32'sd5, 32'sd0, 1'b0));
    write_tolerance({TOL_W{1'b1}});
    send_node(node_req(1'b0, 24'd10, 32'h3FFF_FFFF, 32'hC000_0001, 1'b0));
    send_node(node_req(1'b0, 24'd11, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0));
    send_node(node_req(1'b0, 24'd12, 32'h8000_0000, 32'h8000_0000, 1'b0));
    send_node(node_req(1'b1, 24'd13, 32'h8000_0000, 32'h8000_0000, 1'b1));
    send_node(node_req(1'b0, 24'd14, 32'sd0, 32'sd0, 1'b0));

    write_tolerance(TOL_W'($urandom_range(1, 32'h0004_0000)));
    run_sets(140);

    send_idle_pct = 67;
    recv_idle_pct = 26;
    // fill part of the store with nodes that all hit the first entry
    write_tolerance(TOL_W'(32'h0001_0000));
    base = $signed($urandom()) / 2;
    for (k = 0; k < FILL_NODES; k++) begin
      send_node(node_req(k == 0, ID_W'($urandom_range(1, 24'hFF_FFFF)),
                         base + $urandom_range(0, 16'h7FFE),
                         base + $urandom_range(0, 16'h7FFE), 1'b0));
    end
    send_node(node_req(1'b0, 24'h00_ABCD, base + 16, base, 1'b0));
    send_node(node_req(1'b0, 24'h12_3456, base + 32'h0004_0000, base, 1'b0));
    send_node(node_req(1'b0, 24'h65_4321, base, base, 1'b1));
    send_node(node_req(1'b0, 24'd0, base, base, 1'b0));
    send_node(node_req(1'b1, 24'h80_0001, base, base, 1'b0));
    write_tolerance(TOL_W'($urandom()));
    run_sets(140);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_tolerance(TOL_W'($urandom_range(1, 256)));
    start_hold <= 1'b1;
    @(posedge clk);
    start_hold <= 1'b0;
    run_sets(150);

    in_valid <= 1'b0;
    while (merges.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (merges.errors == 0) begin
      $display("[coincident_node_merger] OK");
    end else begin
      $display("[coincident_node_merger] ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/cnm_pkg.sv
rtl/cnm_front.sv
rtl/cnm_back.sv
rtl/coincident_node_merger.sv
dv/tb_coincident_node_merger.sv
